@@ sv/pafk_pkg.sv @@
// ============================================================================
// pafk_pkg
// Shared types and constants for the planar arm forward kinematics unit.
// ============================================================================
package pafk_pkg;

    // Q15.8 result limits
    localparam int Q15_8_MAX = 8388607;
    localparam int Q15_8_MIN = -8388608;

    // CORDIC datapath: 30 fraction bits, guard bits for growth and sign
    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_Z_W   = 33;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // segment queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // size fields and end-of-arm flag of one segment
    typedef struct packed {
        logic [15:0] size_x;
        logic [15:0] size_y;
        logic [15:0] size_z;
        logic        last;
    } t_seg_payload;

    // queue occupancy status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // arctangent of 2^-i as a 32-bit phase (2^32 per turn)
    function automatic logic signed [CORDIC_Z_W-1:0] atan_phase(input int idx);
        logic signed [CORDIC_Z_W-1:0] v;
        case (idx)
            0:  v = 33'sd536870912;
            1:  v = 33'sd316933406;
            2:  v = 33'sd167458907;
            3:  v = 33'sd85004756;
            4:  v = 33'sd42667331;
            5:  v = 33'sd21354465;
            6:  v = 33'sd10679838;
            7:  v = 33'sd5340245;
            8:  v = 33'sd2670163;
            9:  v = 33'sd1335087;
            10: v = 33'sd667544;
            11: v = 33'sd333772;
            12: v = 33'sd166886;
            13: v = 33'sd83443;
            14: v = 33'sd41722;
            15: v = 33'sd20861;
            16: v = 33'sd10430;
            17: v = 33'sd5215;
            18: v = 33'sd2608;
            19: v = 33'sd1304;
            20: v = 33'sd652;
            21: v = 33'sd326;
            22: v = 33'sd163;
            23: v = 33'sd81;
            24: v = 33'sd41;
            25: v = 33'sd20;
            26: v = 33'sd10;
            27: v = 33'sd5;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/pafk_front.sv @@
// ============================================================================
// pafk_front
// Accepts segments, keeps the running joint angle sum and pushes each
// segment with its absolute angle into the queue.
// ============================================================================
module pafk_front
    import pafk_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [15:0]           i_joint_angle,
    input  logic [15:0]           i_size_x,
    input  logic [15:0]           i_size_y,
    input  logic [15:0]           i_size_z,
    input  logic                  i_last_segment,
    input  t_q_status             i_q_status,
    output logic                  o_push,
    output logic [ANGLE_BITS-1:0] o_sum,
    output t_seg_payload          o_pl
);

    logic [ANGLE_BITS-1:0] r_sum;
    logic [ANGLE_BITS-1:0] n_sum;
    logic [31:0]           w_joint_phase;
    logic [ANGLE_BITS-1:0] w_joint;

    // joint angle as the top bits of a 32-bit phase
    assign w_joint_phase = {i_joint_angle, 16'h0000};
    assign w_joint       = w_joint_phase[31 -: ANGLE_BITS];
    assign n_sum         = r_sum + w_joint;

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;
    assign o_sum   = n_sum;
    assign o_pl    = '{size_x: i_size_x, size_y: i_size_y,
                       size_z: i_size_z, last: i_last_segment};

    // running sum, cleared after the last segment of an arm
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (o_push) begin
            r_sum <= i_last_segment ? '0 : n_sum;
        end
    end

endmodule

@@ sv/pafk_queue.sv @@
// ============================================================================
// pafk_queue
// Short FIFO of segments between the front and the trig/matrix back end.
// ============================================================================
module pafk_queue
    import pafk_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [ANGLE_BITS-1:0] i_sum,
    input  t_seg_payload          i_pl,
    input  logic                  i_pop,
    output t_q_status             o_status,
    output logic [ANGLE_BITS-1:0] o_sum,
    output t_seg_payload          o_pl
);

    logic [ANGLE_BITS-1:0] r_sum_q [0:Q_DEPTH-1];
    t_seg_payload          r_pl_q  [0:Q_DEPTH-1];
    logic [Q_PTR_W-1:0]    r_wr_ptr;
    logic [Q_PTR_W-1:0]    r_rd_ptr;
    logic [Q_CNT_W-1:0]    r_count;
    logic                  w_wr;
    logic                  w_rd;

    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_wr = i_push && !o_status.full;
    assign w_rd = i_pop && !o_status.empty;

    assign o_sum = r_sum_q[r_rd_ptr];
    assign o_pl  = r_pl_q[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_sum_q[r_wr_ptr] <= i_sum;
            r_pl_q[r_wr_ptr]  <= i_pl;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_rd) r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ sv/pafk_back.sv @@
// ============================================================================
// pafk_back
// Pipelined CORDIC sin/cos, matrix products with rounding and saturation,
// and the joint offset accumulator feeding the output register.
// ============================================================================
module pafk_back
    import pafk_pkg::*;
#(
    parameter int ANGLE_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_q_status             i_q_status,
    input  logic [ANGLE_BITS-1:0] i_q_sum,
    input  t_seg_payload          i_q_pl,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [23:0]    o_m_xx,
    output logic signed [23:0]    o_m_yy,
    output logic signed [23:0]    o_m_yz,
    output logic signed [23:0]    o_m_zy,
    output logic signed [23:0]    o_m_zz,
    output logic signed [23:0]    o_t_y,
    output logic signed [23:0]    o_t_z,
    output logic                  o_last_result
);

    localparam int SH = 30 - TRIG_FRAC_BITS;
    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int PW = TW + 17;
    localparam logic signed [CORDIC_W-1:0] TRIG_HALF =
        {{(CORDIC_W-1){1'b0}}, 1'b1} << (SH - 1);
    localparam logic signed [CORDIC_W-1:0] TRIG_ONE =
        {{(CORDIC_W-1){1'b0}}, 1'b1} << TRIG_FRAC_BITS;
    localparam logic signed [PW-1:0] PROD_HALF =
        {{(PW-1){1'b0}}, 1'b1} << (TRIG_FRAC_BITS - 1);

    // saturate a rounded product to Q15.8
    function automatic logic signed [23:0] sat24(input logic signed [PW-1:0] v);
        logic signed [23:0] r;
        if (v > Q15_8_MAX)      r = 24'sh7FFFFF;
        else if (v < Q15_8_MIN) r = 24'sh800000;
        else                    r = v[23:0];
        return r;
    endfunction

    // clamp a rounded CORDIC output to [-1, +1]
    function automatic logic signed [TW-1:0] clamp_unit(
        input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W-1:0] r;
        if (v > TRIG_ONE)       r = TRIG_ONE;
        else if (v < -TRIG_ONE) r = -TRIG_ONE;
        else                    r = v;
        return r[TW-1:0];
    endfunction

    logic w_en;

    // CORDIC stages
    logic signed [CORDIC_W-1:0]   r_x    [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0]   r_y    [0:CORDIC_STEPS];
    logic signed [CORDIC_Z_W-1:0] r_z    [0:CORDIC_STEPS];
    logic [1:0]                   r_quad [0:CORDIC_STEPS];
    t_seg_payload                 r_pl   [0:CORDIC_STEPS];
    logic                         r_v    [0:CORDIC_STEPS];

    // trig, product and rounding stages
    logic signed [TW-1:0] r_c, r_s;
    t_seg_payload         r_pl_t, r_pl_p, r_pl_r;
    logic                 r_v_t, r_v_p, r_v_r;
    logic signed [PW-1:0] r_p_cy, r_p_ssz, r_p_sy, r_p_cz;
    logic signed [23:0]   r_yy, r_yz, r_zy, r_zz;

    // output and offset state
    logic                 r_out_v;
    logic signed [23:0]   r_off_y, r_off_z;

    logic [31:0]                w_phase;
    logic signed [CORDIC_W-1:0] w_c_rnd, w_s_rnd;
    logic signed [TW-1:0]       w_c_cl, w_s_cl;
    logic signed [TW-1:0]       n_c, n_s;
    logic signed [PW-1:0]       w_sy, w_sz;
    logic signed [24:0]         w_oy, w_oz;
    logic signed [23:0]         n_off_y, n_off_z;

    assign w_en    = !r_out_v || !i_stall;
    assign o_q_pop = w_en && !i_q_status.empty;
    assign o_valid = r_out_v;

    // stage 0: load the CORDIC start vector from the queue head
    assign w_phase = {i_q_sum, {(32 - ANGLE_BITS){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x[0]    <= CORDIC_GAIN_Q30;
            r_y[0]    <= '0;
            r_z[0]    <= {3'b000, w_phase[29:0]};
            r_quad[0] <= w_phase[31:30];
            r_pl[0]   <= i_q_pl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= o_q_pop;
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (!r_z[i][CORDIC_Z_W-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_phase(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_phase(i);
                end
                r_quad[i+1] <= r_quad[i];
                r_pl[i+1]   <= r_pl[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (w_en) begin
                r_v[i+1] <= r_v[i];
            end
        end
    end

    // round to the trig format, clamp, unfold the quadrant
    assign w_c_rnd = (r_x[CORDIC_STEPS] + TRIG_HALF) >>> SH;
    assign w_s_rnd = (r_y[CORDIC_STEPS] + TRIG_HALF) >>> SH;
    assign w_c_cl  = clamp_unit(w_c_rnd);
    assign w_s_cl  = clamp_unit(w_s_rnd);

    always_comb begin
        case (r_quad[CORDIC_STEPS])
            2'd0:    begin n_c = w_c_cl;  n_s = w_s_cl;  end
            2'd1:    begin n_c = -w_s_cl; n_s = w_c_cl;  end
            2'd2:    begin n_c = -w_c_cl; n_s = -w_s_cl; end
            default: begin n_c = w_s_cl;  n_s = -w_c_cl; end
        endcase
    end

    // sizes as signed product operands
    assign w_sy = PW'($signed({1'b0, r_pl_t.size_y}));
    assign w_sz = PW'($signed({1'b0, r_pl_t.size_z}));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // trig stage
            r_c    <= n_c;
            r_s    <= n_s;
            r_pl_t <= r_pl[CORDIC_STEPS];
            // product stage
            r_p_cy  <= PW'(r_c) * w_sy;
            r_p_ssz <= PW'(r_s) * w_sz;
            r_p_sy  <= PW'(r_s) * w_sy;
            r_p_cz  <= PW'(r_c) * w_sz;
            r_pl_p  <= r_pl_t;
            // round half up and saturate
            r_yy   <= sat24((r_p_cy + PROD_HALF) >>> TRIG_FRAC_BITS);
            r_yz   <= sat24((PROD_HALF - r_p_ssz) >>> TRIG_FRAC_BITS);
            r_zy   <= sat24((r_p_sy + PROD_HALF) >>> TRIG_FRAC_BITS);
            r_zz   <= sat24((r_p_cz + PROD_HALF) >>> TRIG_FRAC_BITS);
            r_pl_r <= r_pl_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_t <= 1'b0;
            r_v_p <= 1'b0;
            r_v_r <= 1'b0;
        end else if (w_en) begin
            r_v_t <= r_v[CORDIC_STEPS];
            r_v_p <= r_v_t;
            r_v_r <= r_v_p;
        end
    end

    // offset advance with saturation
    assign w_oy = {r_off_y[23], r_off_y} + {r_yz[23], r_yz};
    assign w_oz = {r_off_z[23], r_off_z} + {r_zz[23], r_zz};

    always_comb begin
        if (w_oy[24] != w_oy[23]) n_off_y = w_oy[24] ? 24'sh800000 : 24'sh7FFFFF;
        else                      n_off_y = w_oy[23:0];
        if (w_oz[24] != w_oz[23]) n_off_z = w_oz[24] ? 24'sh800000 : 24'sh7FFFFF;
        else                      n_off_z = w_oz[23:0];
    end

    // output register; results for the segment carry the offset before update
    always_ff @(posedge i_clk) begin
        if (w_en && r_v_r) begin
            o_m_xx        <= {8'h00, r_pl_r.size_x};
            o_m_yy        <= r_yy;
            o_m_yz        <= r_yz;
            o_m_zy        <= r_zy;
            o_m_zz        <= r_zz;
            o_t_y         <= r_off_y;
            o_t_z         <= r_off_z;
            o_last_result <= r_pl_r.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_off_y <= '0;
            r_off_z <= '0;
        end else if (w_en) begin
            r_out_v <= r_v_r;
            if (r_v_r) begin
                r_off_y <= r_pl_r.last ? '0 : n_off_y;
                r_off_z <= r_pl_r.last ? '0 : n_off_z;
            end
        end
    end

endmodule

@@ sv/planar_arm_forward_kinematics_unit.sv @@
// ============================================================================
// planar_arm_forward_kinematics_unit
// Forward kinematics of a planar serial arm, one segment per request.
// ============================================================================
// Segments arrive in chain order and one is taken every clock cycle while
// the queue is not full; each request passes the segment queue, the load
// stage, 28 CORDIC stages, trig, product and rounding stages and the output
// register before its result shows on the output ports. The joint angle sum
// is accumulated at the input side and the joint offset in the output stage,
// one add each per cycle, which sets the one-per-cycle rate when the output
// is not stalled. A stalled output holds the pipeline; the four-entry queue
// keeps the input side taking requests until it fills. A request with
// last_segment set closes the arm and the next request starts from zero.
module planar_arm_forward_kinematics_unit
    import pafk_pkg::*;
#(
    parameter int ANGLE_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_joint_angle,
    input  logic [15:0]        i_size_x,
    input  logic [15:0]        i_size_y,
    input  logic [15:0]        i_size_z,
    input  logic               i_last_segment,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [23:0] o_m_xx,
    output logic signed [23:0] o_m_yy,
    output logic signed [23:0] o_m_yz,
    output logic signed [23:0] o_m_zy,
    output logic signed [23:0] o_m_zz,
    output logic signed [23:0] o_t_y,
    output logic signed [23:0] o_t_z,
    output logic               o_last_result
);

    t_q_status             w_q_status;
    logic                  w_push;
    logic                  w_pop;
    logic [ANGLE_BITS-1:0] w_push_sum;
    logic [ANGLE_BITS-1:0] w_head_sum;
    t_seg_payload          w_push_pl;
    t_seg_payload          w_head_pl;

    pafk_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_joint_angle  (i_joint_angle),
        .i_size_x       (i_size_x),
        .i_size_y       (i_size_y),
        .i_size_z       (i_size_z),
        .i_last_segment (i_last_segment),
        .i_q_status     (w_q_status),
        .o_push         (w_push),
        .o_sum          (w_push_sum),
        .o_pl           (w_push_pl)
    );

    pafk_queue #(.ANGLE_BITS(ANGLE_BITS)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_sum    (w_push_sum),
        .i_pl     (w_push_pl),
        .i_pop    (w_pop),
        .o_status (w_q_status),
        .o_sum    (w_head_sum),
        .o_pl     (w_head_pl)
    );

    pafk_back #(
        .ANGLE_BITS     (ANGLE_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (w_q_status),
        .i_q_sum       (w_head_sum),
        .i_q_pl        (w_head_pl),
        .o_q_pop       (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_m_xx        (o_m_xx),
        .o_m_yy        (o_m_yy),
        .o_m_yz        (o_m_yz),
        .o_m_zy        (o_m_zy),
        .o_m_zz        (o_m_zz),
        .o_t_y         (o_t_y),
        .o_t_z         (o_t_z),
        .o_last_result (o_last_result)
    );

endmodule

@@ sv/pafk_checker.sv @@
// ============================================================================
// pafk_checker
// Port-level checks for the planar arm forward kinematics unit.
// ============================================================================
module pafk_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [23:0] o_m_xx,
    input logic signed [23:0] o_m_yy,
    input logic signed [23:0] o_m_yz,
    input logic signed [23:0] o_m_zy,
    input logic signed [23:0] o_m_zz,
    input logic signed [23:0] o_t_y,
    input logic signed [23:0] o_t_z,
    input logic               o_last_result
);

    // no result survives a reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_t_y) && $stable(o_t_z)
            && $stable(o_m_yy) && $stable(o_m_zz) && $stable(o_last_result))
        else $error("stalled result changed");

    // the x scale entry is the unsigned size
    a_xx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_m_xx[23:16] == 8'h00)
        else $error("m_xx outside the size range");

    // trig times a 16-bit size never exceeds the size range
    a_entry_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_m_yz <= 24'sd65535 && o_m_yz >= -24'sd65535
            && o_m_zz <= 24'sd65535 && o_m_zz >= -24'sd65535
            && o_m_yy <= 24'sd65535 && o_m_yy >= -24'sd65535
            && o_m_zy <= 24'sd65535 && o_m_zy >= -24'sd65535)
        else $error("rotation entry beyond the size range");

endmodule

bind planar_arm_forward_kinematics_unit pafk_checker u_pafk_checker (.*);
